// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_QUERY      = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] position;
    logic [7:0] value;
  } request_t;

  typedef struct packed {
    logic [7:0] front_value;
    logic [7:0] back_value;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       rejected;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

// ===== hw/rtl/bdq_ctrl.sv =====
module bdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output bdq_pkg::ctrl_t ctrl
);

  bdq_pkg::state_t state;
  bdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    busy         = 1'b0;
    done         = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_next   = bdq_pkg::ST_EXEC;
        end
      end
      bdq_pkg::ST_EXEC: begin
        busy         = 1'b1;
        ctrl.execute = 1'b1;
        state_next   = bdq_pkg::ST_REPORT;
      end
      bdq_pkg::ST_REPORT: begin
        done = 1'b1;
        if (start) begin
          ctrl.capture = 1'b1;
          state_next   = bdq_pkg::ST_EXEC;
        end else begin
          state_next = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bdq_datapath.sv =====
module bdq_datapath #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  bdq_pkg::ctrl_t    ctrl,
  input  bdq_pkg::request_t request,
  output bdq_pkg::result_t  result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  bdq_pkg::request_t req;
  logic [7:0]        cells [CAPACITY];
  logic [CNT_W-1:0]  occ;
  logic              rej;

  logic              full;
  logic              pos_ge;
  logic              do_insert;
  logic              do_pop_front;
  logic              do_pop_back;
  logic              rej_next;
  logic [IDX_W-1:0]  ins_idx;
  logic [IDX_W-1:0]  back_idx;
  logic [CNT_W+4:0]  occ_ext;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req <= request;
    end
  end

  assign full   = (occ == CNT_W'(CAPACITY));
  assign pos_ge = (CMP_W'(req.position) >= CMP_W'(occ));

  always_comb begin
    do_insert    = 1'b0;
    do_pop_front = 1'b0;
    do_pop_back  = 1'b0;
    rej_next     = 1'b0;
    ins_idx      = IDX_W'(occ);
    case (req.command) inside
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_INSERT: begin
        rej_next  = full;
        do_insert = !full;
        if (req.command == bdq_pkg::CMD_PUSH_FRONT) begin
          ins_idx = '0;
        end else if (req.command == bdq_pkg::CMD_INSERT && !pos_ge) begin
          ins_idx = IDX_W'(req.position);
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        do_pop_front = (occ != '0);
      end
      bdq_pkg::CMD_POP_BACK: begin
        do_pop_back = (occ != '0);
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctrl.execute) begin
        if (do_insert) begin
          if (IDX_W'(i) == ins_idx) begin
            cells[i] <= req.value;
          end else if (i > 0 && IDX_W'(i) > ins_idx) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (do_pop_front && i < CAPACITY - 1) begin
          cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      rej <= 1'b0;
    end else if (ctrl.execute) begin
      rej <= rej_next;
      if (do_insert) begin
        occ <= occ + CNT_W'(1);
      end else if (do_pop_front || do_pop_back) begin
        occ <= occ - CNT_W'(1);
      end
    end
  end

  assign back_idx = IDX_W'(occ - CNT_W'(1));
  assign occ_ext  = {5'b0, occ};

  always_comb begin
    result.entry_count = occ_ext[4:0];
    result.rejected    = rej;
    result.is_empty    = (occ == '0);
    if (occ == '0) begin
      result.front_value = '0;
      result.back_value  = '0;
    end else begin
      result.front_value = cells[0];
      result.back_value  = cells[back_idx];
    end
  end

endmodule

// ===== hw/rtl/bounded_deque_with_insert_core.sv =====
// channel   signals                 transfer when
// request   start, busy, request    start high and busy low at a rising edge
// result    done, result            done high, one cycle, no backpressure
//
// an item has two steps: capture the request, then shift the cell chain
// the result shows in the cycle after the shift, and a new request may transfer then
// busy is high only in the shift cycle
// synchronous reset empties the store; entry contents stay undefined until written
// results cannot be stalled by the receiver
module bounded_deque_with_insert_core #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bdq_pkg::request_t request,
  output logic              done,
  output bdq_pkg::result_t  result
);

  bdq_pkg::ctrl_t ctrl;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  bdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .request (request),
    .result  (result)
  );

endmodule
